// File: design/key_debounce_press_classifier_top_defines.svh
// Assertion macros shared by the key debounce / press classifier RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_TOP_DEFINES_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define KDPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define KDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kdpc_pkg.sv
// Shared types and constants for the key debounce / press classifier.
// No dependencies; imported by the scan and register interfaces and all modules.
package kdpc_pkg;

  localparam int SAMPLES_PER_SCAN = 4;
  localparam int RAW_W            = 4;
  localparam int HIST_W           = 3;
  localparam int MS_W             = 16;
  localparam int CFG_IDX_W        = 2;

  localparam logic [MS_W-1:0] TIMER_MAX = '1;

  // pending press codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 2'd2;

  localparam logic [MS_W-1:0] LONG_PRESS_RST    = 16'd1000;
  localparam logic [MS_W-1:0] SCAN_INTERVAL_RST = 16'd10;

  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic              down;
  } deb_state_t;

endpackage

// File: design/kdpc_if.sv
// Valid/ready channel interfaces: scan input, press result, register write.
// Depends on kdpc_pkg for field widths.
interface kdpc_in_if import kdpc_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_samples;

  modport source (output valid, output raw_samples, input ready);
  modport sink   (input valid, input raw_samples, output ready);
endinterface

interface kdpc_out_if;
  logic valid;
  logic ready;
  logic press_kind;

  modport source (output valid, output press_kind, input ready);
  modport sink   (input valid, input press_kind, output ready);
endinterface

interface kdpc_cfg_if import kdpc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MS_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/kdpc_debounce.sv
// Four-in-a-row debounce over one scan's samples, oldest sample first.
// Depends on kdpc_pkg.
module kdpc_debounce import kdpc_pkg::*; (
  input  logic [RAW_W-1:0] raw_samples,
  input  logic             active_level,
  input  deb_state_t       state_cur,
  output deb_state_t       state_nxt
);

  // samples past the field read as pin low
  logic [SAMPLES_PER_SCAN+RAW_W-1:0] raw_ext;
  assign raw_ext = {{SAMPLES_PER_SCAN{1'b0}}, raw_samples};

  always_comb begin
    logic [HIST_W:0] win;
    logic [HIST_W-1:0] hist;
    logic down;
    hist = state_cur.hist;
    down = state_cur.down;
    for (int i = 0; i < SAMPLES_PER_SCAN; i++) begin
      win = {hist, raw_ext[i] == active_level};
      if (&win) begin
        down = 1'b1;
      end else if (~|win) begin
        down = 1'b0;
      end
      hist = win[HIST_W-1:0];
    end
    state_nxt.hist = hist;
    state_nxt.down = down;
  end

endmodule

// File: design/key_debounce_press_classifier_top.sv
// A scan is held in the input register, then any press it completes in the result register.
// Throughput: one scan per cycle unless stalled. Per scan: the debounce window
// plus one 16-bit saturating add and compare, between input and result registers.
// Reset (rst_n low, synchronous): key up, no press pending, timer and history
// cleared, active_level 0, long_press_ms 1000, scan_interval_ms 10.
// Top level: depends on kdpc_pkg, kdpc_if, kdpc_debounce and the defines header.
`include "key_debounce_press_classifier_top_defines.svh"

module key_debounce_press_classifier_top import kdpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  kdpc_in_if.sink      in_ch,
  kdpc_out_if.source   out_ch,
  kdpc_cfg_if.sink     cfg_ch
);

  // configuration
  logic            active_level_r;
  logic [MS_W-1:0] long_press_r;
  logic [MS_W-1:0] scan_interval_r;

  // input stage
  logic             s1_valid_r;
  logic [RAW_W-1:0] s1_raw_r;

  // key state
  deb_state_t      deb_r;
  deb_state_t      deb_nxt;
  logic [1:0]      pending_r;
  logic [1:0]      pending_nxt;
  logic [MS_W-1:0] hold_timer_r;
  logic [MS_W-1:0] hold_timer_nxt;

  // result stage
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_kind_r;

  logic          s1_fire;
  logic          emit;
  logic [MS_W:0] sum;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r  <= 1'b0;
      long_press_r    <= LONG_PRESS_RST;
      scan_interval_r <= SCAN_INTERVAL_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ACTIVE_LEVEL:  active_level_r  <= cfg_ch.data[0];
        REG_LONG_PRESS:    long_press_r    <= cfg_ch.data;
        REG_SCAN_INTERVAL: scan_interval_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // stage 1 moves on whenever the result register is free or draining
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw_r <= in_ch.raw_samples;
    end
  end

  kdpc_debounce u_debounce (
    .raw_samples  (s1_raw_r),
    .active_level (active_level_r),
    .state_cur    (deb_r),
    .state_nxt    (deb_nxt)
  );

  assign sum = {1'b0, hold_timer_r} + {1'b0, scan_interval_r};

  always_comb begin
    emit = 1'b0;
    if (deb_nxt.down) begin
      hold_timer_nxt = sum[MS_W] ? TIMER_MAX : sum[MS_W-1:0];
      pending_nxt    = (hold_timer_nxt >= long_press_r) ? KIND_LONG : KIND_SHORT;
    end else begin
      hold_timer_nxt = '0;
      pending_nxt    = KIND_NONE;
      emit           = (pending_r != KIND_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r        <= '0;
      pending_r    <= KIND_NONE;
      hold_timer_r <= '0;
    end else if (s1_fire) begin
      deb_r        <= deb_nxt;
      pending_r    <= pending_nxt;
      hold_timer_r <= hold_timer_nxt;
    end
  end

  assign out_valid_nxt = (s1_fire && emit) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_kind_r <= (pending_r == KIND_LONG);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.press_kind = out_kind_r;

  `KDPC_ASSERT_NOW(a_idle_timer_clear, clk, rst_n, pending_r == KIND_NONE,
    hold_timer_r == '0, "timer nonzero with no press pending")
  `KDPC_ASSERT_NOW(a_down_has_pending, clk, rst_n, deb_r.down,
    pending_r != KIND_NONE, "key down without a pending press")
  `KDPC_ASSERT_NOW(a_emit_only_up, clk, rst_n, s1_fire && emit,
    !deb_nxt.down, "press result on a tick with the key down")
  `KDPC_ASSERT_NEXT(a_stall_holds_s1, clk, rst_n, s1_valid_r && out_valid_r && !out_ch.ready,
    s1_valid_r, "scan lost while result stalled")

endmodule

// File: tb/kdpc_tb_pkg.sv
`timescale 1ns / 100ps
// Press-kind tracker for the key debounce / press classifier testbench.
// Depends on kdpc_pkg for widths, press codes and register indexes.
package kdpc_tb_pkg;
  import kdpc_pkg::*;

  class press_tracker;
    logic            active_level;
    logic [MS_W-1:0] long_press_ms;
    logic [MS_W-1:0] scan_interval_ms;

    logic [HIST_W-1:0] match_hist;
    logic              is_down;
    logic [1:0]        pending_kind;
    logic [MS_W-1:0]   hold_ms;

    logic        expected_kinds[$];
    int unsigned errors;

    function new();
      active_level     = 1'b0;
      long_press_ms    = LONG_PRESS_RST;
      scan_interval_ms = SCAN_INTERVAL_RST;
      match_hist       = '0;
      is_down          = 1'b0;
      pending_kind     = KIND_NONE;
      hold_ms          = '0;
      errors           = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] data);
      case (idx)
        REG_ACTIVE_LEVEL:  active_level = data[0];
        REG_LONG_PRESS:    long_press_ms = data;
        REG_SCAN_INTERVAL: scan_interval_ms = data;
        default: ;
      endcase
    endfunction

    // Advance the key state by one accepted scan; queue the press it completes.
    function void note_scan(logic [RAW_W-1:0] raw);
      logic [HIST_W:0] window;
      logic            sample;
      logic [MS_W:0]   sum;
      for (int i = 0; i < SAMPLES_PER_SCAN; i++) begin
        sample = (i < RAW_W) ? raw[i] : 1'b0;
        window = {match_hist, sample == active_level};
        if (window == '1) begin
          is_down = 1'b1;
        end else if (window == '0) begin
          is_down = 1'b0;
        end
        match_hist = window[HIST_W-1:0];
      end
      if (is_down) begin
        sum = {1'b0, hold_ms} + {1'b0, scan_interval_ms};
        hold_ms = sum[MS_W] ? TIMER_MAX : sum[MS_W-1:0];
        pending_kind = (hold_ms >= long_press_ms) ? KIND_LONG : KIND_SHORT;
      end else begin
        hold_ms = '0;
        if (pending_kind != KIND_NONE) begin
          expected_kinds.push_back(pending_kind == KIND_LONG);
          pending_kind = KIND_NONE;
        end
      end
    endfunction

    function void check_press(logic kind);
      logic want;
      if (expected_kinds.size() == 0) begin
        $display("%0t: unexpected press result, expected none actual %0b", $time, kind);
        errors++;
      end else begin
        want = expected_kinds.pop_front();
        if (kind !== want) begin
          $display("%0t: press_kind mismatch, expected %0b actual %0b", $time, want, kind);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_kinds.size();
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for key_debounce_press_classifier_top: drives scans and
// register writes, checks press results. Depends on kdpc_pkg, kdpc_if, kdpc_tb_pkg.
module tb_top;
  import kdpc_pkg::*;
  import kdpc_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int HOLD_OFF_LEN  = 80;
  localparam int ITEMS_PER_SEG = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  kdpc_in_if  in_ch();
  kdpc_out_if out_ch();
  kdpc_cfg_if cfg_ch();

  key_debounce_press_classifier_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  press_tracker sb = new();

  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned scans_sent = 0;
  bit          hold_off_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_press(out_ch.press_kind);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_scan(logic [RAW_W-1:0] raw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_samples <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_scan(raw);
    scans_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // scans that complete no press may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_key(logic level, logic [MS_W-1:0] long_ms, logic [MS_W-1:0] step_ms);
    wait_drained();
    write_reg(REG_ACTIVE_LEVEL, {{(MS_W-1){1'b0}}, level});
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_SCAN_INTERVAL, step_ms);
  endtask

  task automatic configure_random();
    logic [MS_W-1:0] step_ms;
    logic [MS_W-1:0] long_ms;
    int unsigned     mode;
    mode = $urandom_range(3);
    case (mode)
      0: begin
        step_ms = MS_W'($urandom_range(1, 20));
        long_ms = MS_W'(step_ms * $urandom_range(0, 10));
      end
      1: begin
        step_ms = '0;
        long_ms = $urandom_range(1) ? '0 : MS_W'($urandom_range(1, 16));
      end
      2: begin
        step_ms = MS_W'($urandom_range(16'h4000, 16'hFFFF));
        long_ms = $urandom_range(1) ? TIMER_MAX : MS_W'($urandom_range(16'h8000, 16'hFFFF));
      end
      default: begin
        step_ms = MS_W'($urandom);
        long_ms = MS_W'($urandom);
      end
    endcase
    wait_drained();
    // full-width data on the 1-bit register: only bit 0 counts
    write_reg(REG_ACTIVE_LEVEL, MS_W'($urandom));
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_SCAN_INTERVAL, step_ms);
    if (mode == 3) write_reg(REG_UNUSED, MS_W'($urandom));
  endtask

  // One press (or at times one random scan): optional bounce, a hold with rare glitches, bounce, release.
  task automatic send_press();
    logic [RAW_W-1:0] on_nib;
    on_nib = {RAW_W{sb.active_level}};
    if ($urandom_range(99) < 15) begin
      send_scan(RAW_W'($urandom));
    end else begin
      repeat ($urandom_range(0, 2)) send_scan(RAW_W'($urandom));
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(99) < 10) begin
          send_scan(on_nib ^ (4'b0001 << $urandom_range(RAW_W-1)));
        end else begin
          send_scan(on_nib);
        end
      end
      repeat ($urandom_range(0, 2)) send_scan(RAW_W'($urandom));
      repeat ($urandom_range(1, 3)) send_scan(~on_nib);
    end
  endtask

  task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct, bit hold_off);
    int unsigned seg_end;
    wait_drained();
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    if (hold_off) begin
      // flood completed presses while the receiver is stalled
      hold_off_req = 1'b1;
      repeat (20) begin
        send_scan({RAW_W{sb.active_level}});
        send_scan(~{RAW_W{sb.active_level}});
      end
    end
    repeat (3) begin
      configure_random();
      seg_end = scans_sent + ITEMS_PER_SEG;
      while (scans_sent < seg_end) send_press();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.raw_samples = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: active low, 1000 ms threshold, 10 ms per tick
    send_scan(4'h0);
    send_scan(4'hF);
    send_scan(4'h5);
    send_scan(4'hA);
    send_scan(4'hC);
    send_scan(4'h3);
    send_scan(4'hF);

    // zero threshold and zero interval: any hold is long
    set_key(1'b1, '0, '0);
    send_scan(4'hF);
    send_scan(4'h0);

    // timer saturation
    set_key(1'b1, TIMER_MAX, TIMER_MAX);
    send_scan(4'hF);
    send_scan(4'hF);
    send_scan(4'h0);
    wait_drained();
    write_reg(REG_SCAN_INTERVAL, 16'h8000);
    send_scan(4'hF);
    send_scan(4'hF);
    send_scan(4'h0);

    // zero interval with a nonzero threshold: stays short
    set_key(1'b1, 16'd5, '0);
    send_scan(4'hF);
    send_scan(4'hF);
    send_scan(4'h0);

    // oversized value on the level register, write to an unused index
    wait_drained();
    write_reg(REG_ACTIVE_LEVEL, 16'hFFFE);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_scan(4'h0);
    send_scan(4'h1);
    send_scan(4'h8);
    send_scan(4'hF);

    run_phase(32, 86, 1'b0);
    run_phase(86, 32, 1'b0);
    run_phase(0, 0, 1'b1);

    wait_drained();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
